// File: src/dilv_pkg.sv
// Shared types, character codes, limits and helper functions for the decimal
// integer list validator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dilv_pkg;

  // Default depth of the table of values seen in one list
  localparam int MaxTokensDef = 64;

  localparam int ValueW = 32;

  // Token length saturates here; longer tokens are out of range anyway
  localparam logic [3:0] LenCap = 4'd12;
  // Longest token that can still be in range (sign included)
  localparam logic [3:0] LenSignedMax = 4'd11;
  // Longest unsigned token that needs the digit-wise compare
  localparam logic [3:0] LenUnsignedMax = 4'd10;
  // Digit positions that take part in the limit compare
  localparam logic [3:0] LimitDigits = 4'd10;

  localparam logic [6:0] TotalCap = 7'd64;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus = 8'h2B;
  localparam logic [7:0] Char0 = 8'h30;
  localparam logic [7:0] Char9 = 8'h39;

  typedef enum logic [2:0] {
    ReasonNone   = 3'd0,
    ReasonFormat = 3'd1,
    ReasonRange  = 3'd2,
    ReasonDup    = 3'd3,
    ReasonEmpty  = 3'd4,
    ReasonFull   = 3'd5
  } dilv_reason_e;

  typedef enum logic [1:0] {
    RcEqual   = 2'd0,
    RcLess    = 2'd1,
    RcGreater = 2'd2
  } dilv_cmp_e;

  // Flags that travel with a value down the row of table cells
  typedef struct packed {
    logic valid;
    logic dup;
    logic stored;
  } dilv_flags_t;

  // Limit digit at a position of the magnitude; the last one depends on sign
  function automatic logic [7:0] lim_digit(input logic [3:0] di, input logic neg);
    logic [7:0] lim;
    unique case (di)
      4'd0:    lim = 8'h32;
      4'd1:    lim = 8'h31;
      4'd2:    lim = 8'h34;
      4'd3:    lim = 8'h37;
      4'd4:    lim = 8'h34;
      4'd5:    lim = 8'h38;
      4'd6:    lim = 8'h33;
      4'd7:    lim = 8'h36;
      4'd8:    lim = 8'h34;
      default: lim = neg ? 8'h38 : 8'h37;
    endcase
    return lim;
  endfunction

  // Format and range faults override a held duplicate or table-full fault
  function automatic dilv_reason_e raise_format(input dilv_reason_e cur,
                                                input dilv_reason_e code);
    dilv_reason_e res;
    res = cur;
    if (cur == ReasonNone || cur == ReasonDup || cur == ReasonFull) begin
      res = code;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/dilv_cell.sv
// One cell of the seen-value table: holds one stored value and passes the
// search packet on to its neighbour each cycle. Uses dilv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dilv_cell #(
  parameter int CNT_W = 7
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire dilv_pkg::dilv_flags_t      flags_i,
  input  wire [dilv_pkg::ValueW-1:0]      value_i,
  input  wire [CNT_W-1:0]                 remain_i,
  output dilv_pkg::dilv_flags_t           flags_o,
  output logic [dilv_pkg::ValueW-1:0]     value_o,
  output logic [CNT_W-1:0]                remain_o
);

  dilv_pkg::dilv_flags_t          flags_q, flags_d;
  logic [dilv_pkg::ValueW-1:0]    value_q;
  logic [CNT_W-1:0]               remain_q, remain_d;
  logic [dilv_pkg::ValueW-1:0]    slot_q;
  logic                           occupied;
  logic                           hit;
  logic                           wr;

  // A non-zero countdown means this cell holds a value of the current list
  assign occupied = (remain_i != '0);
  assign hit      = occupied && (slot_q == value_i);
  // First free cell takes the value unless a match was found upstream
  assign wr       = flags_i.valid && !occupied && !flags_i.dup && !flags_i.stored;

  always_comb begin
    flags_d        = flags_i;
    flags_d.dup    = flags_i.dup | (flags_i.valid & hit);
    flags_d.stored = flags_i.stored | wr;
    remain_d       = occupied ? (remain_i - CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_i;
    remain_q <= remain_d;
    if (wr) begin
      slot_q <= value_i;
    end
  end

  assign flags_o  = flags_q;
  assign value_o  = value_q;
  assign remain_o = remain_q;

endmodule

`default_nettype wire

// File: src/decimal_int_list_validator.sv
// Top level of the decimal integer list validator: token parser, list state,
// verdict register and a row of dilv_cell table cells. Uses dilv_pkg.
//
// Usage: the input channel carries one item per handshake (in_valid_i high,
// in_stall_o low): an optional character, a token-end flag and a list-end
// flag, applied in that order. The output channel gives one item per list,
// the verdict, the reject reason and the number of tokens closed, when the
// list ends.
// Input flow: an item that only adds a character, or closes a token that
// needs no duplicate search, leaves the block ready for the next item. A
// token that is valid and must be checked against the table walks the row
// of MAX_TOKENS cells, one cell a cycle, and the input stalls until it
// leaves the row. An item that ends the list stalls the input until the
// verdict is in the output register, after the row search when that item
// closes a token that is searched.
// Reset clears the parser, the list state and the output valid flag; the
// table contents need no clearing since only filled cells are compared.
// A stalled output holds its item; the block keeps taking items and only
// waits when a further verdict is ready while the output is still full.
`timescale 1ns / 1ps
`default_nettype none

module decimal_int_list_validator #(
  parameter int MAX_TOKENS = dilv_pkg::MaxTokensDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] ch_i,
  input  wire        has_char_i,
  input  wire        token_end_i,
  input  wire        list_end_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       verdict_o,
  output logic [2:0] reject_reason_o,
  output logic [6:0] token_total_o
);

  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam int VW = dilv_pkg::ValueW;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StEmit   = 3'b100
  } dilv_state_e;

  dilv_state_e               state_q, state_d;

  // Token being parsed
  logic [VW-1:0]             mag_q, mag_d;
  logic [3:0]                len_q, len_d;
  logic                      neg_q, neg_d;
  logic                      sgn_q, sgn_d;
  dilv_pkg::dilv_cmp_e       rc_q, rc_d;

  // List state
  dilv_pkg::dilv_reason_e    err_q, err_d;
  logic [6:0]                tok_cnt_q, tok_cnt_d;
  logic [CW-1:0]             seen_cnt_q, seen_cnt_d;
  logic                      pend_q, pend_d;

  // Search packet entering the row
  dilv_pkg::dilv_flags_t     launch_flags_q, launch_flags_d;
  logic [VW-1:0]             launch_val_q, launch_val_d;
  logic [CW-1:0]             launch_rem_q, launch_rem_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic                      verdict_q, verdict_d;
  logic [2:0]                reason_q, reason_d;
  logic [6:0]                total_q, total_d;
  logic                      out_free;
  dilv_pkg::dilv_reason_e    emit_reason;

  // Character step, applied on top of the held token
  logic [VW-1:0]             c_mag;
  logic [3:0]                c_len;
  logic                      c_neg;
  logic                      c_sgn;
  dilv_pkg::dilv_cmp_e       c_rc;
  dilv_pkg::dilv_reason_e    c_err;
  logic [3:0]                di;
  logic [7:0]                lim;
  logic [7:0]                digit;
  logic                      is_sign;
  logic                      is_digit;

  // Token close
  logic                      do_close;
  logic                      range_bad;
  logic                      launch;
  dilv_pkg::dilv_reason_e    k_err;
  logic [6:0]                tc_next;
  logic [VW-1:0]             value;

  // Row wiring
  dilv_pkg::dilv_flags_t     row_flags [MAX_TOKENS+1];
  logic [VW-1:0]             row_val   [MAX_TOKENS+1];
  logic [CW-1:0]             row_rem   [MAX_TOKENS+1];
  dilv_pkg::dilv_flags_t     exit_flags;

  assign in_stall_o = (state_q != StIdle);

  assign is_sign  = (ch_i == dilv_pkg::CharMinus) || (ch_i == dilv_pkg::CharPlus);
  assign is_digit = (ch_i >= dilv_pkg::Char0) && (ch_i <= dilv_pkg::Char9);
  assign digit    = ch_i - dilv_pkg::Char0;
  assign di       = len_q - {3'b000, sgn_q};
  assign lim      = dilv_pkg::lim_digit(di, neg_q);

  // Take one character into the token
  always_comb begin
    c_mag = mag_q;
    c_len = len_q;
    c_neg = neg_q;
    c_sgn = sgn_q;
    c_rc  = rc_q;
    c_err = err_q;
    if (has_char_i) begin
      if (len_q < dilv_pkg::LenCap) begin
        c_len = len_q + 4'd1;
      end
      if (len_q == 4'd0 && is_sign) begin
        c_sgn = 1'b1;
        c_neg = (ch_i == dilv_pkg::CharMinus);
      end else if (!is_digit) begin
        c_err = dilv_pkg::raise_format(err_q, dilv_pkg::ReasonFormat);
      end else begin
        // times ten as two shifts, then add the digit; wraps modulo 2^32
        c_mag = (mag_q << 3) + (mag_q << 1) + {{(VW-8){1'b0}}, digit};
        if (di < dilv_pkg::LimitDigits && rc_q == dilv_pkg::RcEqual) begin
          if (ch_i < lim) begin
            c_rc = dilv_pkg::RcLess;
          end else if (ch_i > lim) begin
            c_rc = dilv_pkg::RcGreater;
          end
        end
      end
    end
  end

  // Close the token: format, range, then hand it to the table search
  assign do_close  = token_end_i || (list_end_i && (c_len != 4'd0));
  assign range_bad = (c_len > dilv_pkg::LenSignedMax) ||
                     ((c_len == dilv_pkg::LenSignedMax) &&
                      (!c_sgn || c_rc == dilv_pkg::RcGreater)) ||
                     ((c_len == dilv_pkg::LenUnsignedMax) && !c_sgn &&
                      (c_rc == dilv_pkg::RcGreater));
  assign tc_next   = (tok_cnt_q < dilv_pkg::TotalCap) ? (tok_cnt_q + 7'd1) : tok_cnt_q;
  assign value     = c_neg ? ({VW{1'b0}} - c_mag) : c_mag;

  always_comb begin
    k_err  = c_err;
    launch = 1'b0;
    priority if (c_err == dilv_pkg::ReasonFormat || c_err == dilv_pkg::ReasonRange) begin
      k_err = c_err;
    end else if (c_sgn && c_len == 4'd1) begin
      k_err = dilv_pkg::raise_format(c_err, dilv_pkg::ReasonFormat);
    end else if (range_bad) begin
      k_err = dilv_pkg::raise_format(c_err, dilv_pkg::ReasonRange);
    end else if (c_err == dilv_pkg::ReasonNone) begin
      launch = 1'b1;
    end else begin
      k_err = c_err;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_reason = (tok_cnt_q == 7'd0) ? dilv_pkg::ReasonEmpty : err_q;

  always_comb begin
    state_d        = state_q;
    mag_d          = mag_q;
    len_d          = len_q;
    neg_d          = neg_q;
    sgn_d          = sgn_q;
    rc_d           = rc_q;
    err_d          = err_q;
    tok_cnt_d      = tok_cnt_q;
    seen_cnt_d     = seen_cnt_q;
    pend_d         = pend_q;
    launch_flags_d = '0;
    launch_val_d   = launch_val_q;
    launch_rem_d   = launch_rem_q;
    out_valid_d    = out_stall_i ? out_valid_q : 1'b0;
    verdict_d      = verdict_q;
    reason_d       = reason_q;
    total_d        = total_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mag_d = c_mag;
          len_d = c_len;
          neg_d = c_neg;
          sgn_d = c_sgn;
          rc_d  = c_rc;
          err_d = c_err;
          if (do_close) begin
            tok_cnt_d = tc_next;
            err_d     = k_err;
            if (launch) begin
              // Send the value down the row; countdown marks the filled cells
              launch_flags_d.valid = 1'b1;
              launch_val_d         = value;
              launch_rem_d         = seen_cnt_q;
              pend_d               = list_end_i;
              state_d              = StSearch;
            end
          end
          if (do_close || list_end_i) begin
            mag_d = '0;
            len_d = 4'd0;
            neg_d = 1'b0;
            sgn_d = 1'b0;
            rc_d  = dilv_pkg::RcEqual;
          end
          if (list_end_i && !(do_close && launch)) begin
            state_d = StEmit;
          end
        end
      end
      StSearch: begin
        if (exit_flags.valid) begin
          if (exit_flags.dup) begin
            if (err_q == dilv_pkg::ReasonNone) begin
              err_d = dilv_pkg::ReasonDup;
            end
          end else if (exit_flags.stored) begin
            seen_cnt_d = seen_cnt_q + CW'(1);
          end else if (err_q == dilv_pkg::ReasonNone) begin
            err_d = dilv_pkg::ReasonFull;
          end
          state_d = pend_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        // Hold the verdict until the output register has room
        if (out_free) begin
          out_valid_d = 1'b1;
          verdict_d   = (emit_reason == dilv_pkg::ReasonNone);
          reason_d    = emit_reason;
          total_d     = tok_cnt_q;
          err_d       = dilv_pkg::ReasonNone;
          tok_cnt_d   = 7'd0;
          seen_cnt_d  = '0;
          pend_d      = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      mag_q          <= '0;
      len_q          <= 4'd0;
      neg_q          <= 1'b0;
      sgn_q          <= 1'b0;
      rc_q           <= dilv_pkg::RcEqual;
      err_q          <= dilv_pkg::ReasonNone;
      tok_cnt_q      <= 7'd0;
      seen_cnt_q     <= '0;
      pend_q         <= 1'b0;
      launch_flags_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      mag_q          <= mag_d;
      len_q          <= len_d;
      neg_q          <= neg_d;
      sgn_q          <= sgn_d;
      rc_q           <= rc_d;
      err_q          <= err_d;
      tok_cnt_q      <= tok_cnt_d;
      seen_cnt_q     <= seen_cnt_d;
      pend_q         <= pend_d;
      launch_flags_q <= launch_flags_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    launch_val_q <= launch_val_d;
    launch_rem_q <= launch_rem_d;
    verdict_q    <= verdict_d;
    reason_q     <= reason_d;
    total_q      <= total_d;
  end

  // Row of table cells; the packet advances one cell a cycle
  assign row_flags[0] = launch_flags_q;
  assign row_val[0]   = launch_val_q;
  assign row_rem[0]   = launch_rem_q;

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
    dilv_cell #(
      .CNT_W (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .flags_i  (row_flags[g]),
      .value_i  (row_val[g]),
      .remain_i (row_rem[g]),
      .flags_o  (row_flags[g+1]),
      .value_o  (row_val[g+1]),
      .remain_o (row_rem[g+1])
    );
  end

  assign exit_flags = row_flags[MAX_TOKENS];

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign reject_reason_o = reason_q;
  assign token_total_o   = total_q;

`ifndef SYNTHESIS
  a_seen_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_cnt_q <= CW'(MAX_TOKENS))
    else $error("table fill count beyond table depth");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_cnt_q <= dilv_pkg::TotalCap)
    else $error("token total beyond its cap");

  a_exit_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_flags.valid |-> state_q == StSearch)
    else $error("search packet left the row outside a search");

  a_search_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_flags.valid |=> state_q != StSearch)
    else $error("search did not finish on packet exit");

  a_exit_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_flags.valid |-> !(exit_flags.dup && exit_flags.stored))
    else $error("value both matched and stored");
`endif

endmodule

`default_nettype wire

// File: tb/decimal_int_list_validator_tb.sv
// Testbench for decimal_int_list_validator: drives token characters, token
// ends and list ends, predicts each list verdict and checks it on the output.
// Depends on dilv_pkg and the block itself; needs no files or arguments.
`timescale 1ns / 1ps

module decimal_int_list_validator_tb;

  localparam int MAX_TOK = dilv_pkg::MaxTokensDef;
  // Slowest legal run stays well under this
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 350;
  // First nine limit digits of both bounds, most significant first
  localparam logic [71:0] LimHead = "214748364";

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic                   verdict;
    dilv_pkg::dilv_reason_e reason;
    logic [6:0]             total;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] ch_i = '0;
  logic       has_char_i = 1'b0;
  logic       token_end_i = 1'b0;
  logic       list_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       verdict_o;
  logic [2:0] reject_reason_o;
  logic [6:0] token_total_o;

  decimal_int_list_validator #(
    .MAX_TOKENS(MAX_TOK)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .has_char_i     (has_char_i),
    .token_end_i    (token_end_i),
    .list_end_i     (list_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .reject_reason_o(reject_reason_o),
    .token_total_o  (token_total_o)
  );

  // Verdicts predicted but not yet seen on the output, oldest first
  verdict_t verdict_q[$];
  int       fail_n = 0;
  int       item_n = 0;
  int       cyc_n = 0;
  // Random idling on both channels; cleared for a stretch of full-rate traffic
  bit       gaps_on = 1'b1;

  // ---------------------------------------------------------------------
  // Predicted parser and list state
  // ---------------------------------------------------------------------
  logic [31:0]            acc_mag;
  logic [3:0]             tok_len;
  logic                   tok_neg;
  logic                   tok_sgn;
  dilv_pkg::dilv_cmp_e    tok_cmp;
  dilv_pkg::dilv_reason_e list_err;
  logic [31:0]            seen_tab[MAX_TOK];
  int                     seen_n;
  logic [6:0]             tok_total;

  initial begin
    acc_mag   = '0;
    tok_len   = '0;
    tok_neg   = 1'b0;
    tok_sgn   = 1'b0;
    tok_cmp   = dilv_pkg::RcEqual;
    list_err  = dilv_pkg::ReasonNone;
    seen_n    = 0;
    tok_total = '0;
  end

  function automatic void clear_number();
    acc_mag = '0;
    tok_len = '0;
    tok_neg = 1'b0;
    tok_sgn = 1'b0;
    tok_cmp = dilv_pkg::RcEqual;
  endfunction

  // Format and range faults displace a held duplicate or table-full fault
  function automatic void flag_format(input dilv_pkg::dilv_reason_e code);
    if (list_err == dilv_pkg::ReasonNone || list_err == dilv_pkg::ReasonDup ||
        list_err == dilv_pkg::ReasonFull) begin
      list_err = code;
    end
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    logic [3:0] pos;
    logic [3:0] di;
    logic [7:0] lim;
    int         k;
    pos = tok_len;
    if (tok_len < dilv_pkg::LenCap) begin
      tok_len = tok_len + 4'd1;
    end
    // A sign is only a sign in the first position
    if (pos == 4'd0 && (c == dilv_pkg::CharMinus || c == dilv_pkg::CharPlus)) begin
      tok_sgn = 1'b1;
      tok_neg = (c == dilv_pkg::CharMinus);
      return;
    end
    if (c < dilv_pkg::Char0 || c > dilv_pkg::Char9) begin
      flag_format(dilv_pkg::ReasonFormat);
      return;
    end
    acc_mag = acc_mag * 32'd10 + {24'd0, c - dilv_pkg::Char0};
    // Track the digit-wise compare against the limit until it is decided
    di = pos - {3'b000, tok_sgn};
    if (di < dilv_pkg::LimitDigits && tok_cmp == dilv_pkg::RcEqual) begin
      k = di;
      if (k < 9) begin
        lim = LimHead[(8 - k) * 8 +: 8];
      end else begin
        lim = tok_neg ? "8" : "7";
      end
      if (c < lim) begin
        tok_cmp = dilv_pkg::RcLess;
      end else if (c > lim) begin
        tok_cmp = dilv_pkg::RcGreater;
      end
    end
  endfunction

  function automatic void close_number();
    logic [3:0]  len;
    logic        bad_rng;
    logic        hit;
    logic [31:0] val;
    len = tok_len;
    bad_rng = 1'b0;
    if (tok_total < dilv_pkg::TotalCap) begin
      tok_total = tok_total + 7'd1;
    end
    // Once format or range has failed, later tokens are only counted
    if (list_err == dilv_pkg::ReasonFormat || list_err == dilv_pkg::ReasonRange) begin
      clear_number();
      return;
    end
    if (tok_sgn && len == 4'd1) begin
      flag_format(dilv_pkg::ReasonFormat);
      clear_number();
      return;
    end
    if (len > dilv_pkg::LenSignedMax) begin
      bad_rng = 1'b1;
    end else if (len == dilv_pkg::LenSignedMax) begin
      bad_rng = !tok_sgn || tok_cmp == dilv_pkg::RcGreater;
    end else if (len == dilv_pkg::LenUnsignedMax && !tok_sgn) begin
      bad_rng = (tok_cmp == dilv_pkg::RcGreater);
    end
    if (bad_rng) begin
      flag_format(dilv_pkg::ReasonRange);
      clear_number();
      return;
    end
    // Search and store only while the list is still clean
    if (list_err == dilv_pkg::ReasonNone) begin
      val = tok_neg ? 32'd0 - acc_mag : acc_mag;
      hit = 1'b0;
      for (int i = 0; i < seen_n; i++) begin
        if (seen_tab[i] == val) begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        list_err = dilv_pkg::ReasonDup;
      end else if (seen_n < MAX_TOK) begin
        seen_tab[seen_n] = val;
        seen_n++;
      end else begin
        list_err = dilv_pkg::ReasonFull;
      end
    end
    clear_number();
  endfunction

  // Apply one accepted item: character, then token end, then list end
  function automatic void predict_step(input logic [7:0] c, input logic hc,
                                       input logic te, input logic le);
    verdict_t want;
    if (hc) begin
      feed_char(c);
    end
    if (te) begin
      close_number();
    end
    if (le) begin
      // A token still open at list end closes only if it holds a character
      if (tok_len != 4'd0) begin
        close_number();
      end
      want.reason  = (tok_total == 7'd0) ? dilv_pkg::ReasonEmpty : list_err;
      want.verdict = (want.reason == dilv_pkg::ReasonNone);
      want.total   = tok_total;
      verdict_q.push_back(want);
      clear_number();
      list_err  = dilv_pkg::ReasonNone;
      seen_n    = 0;
      tok_total = '0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock, cycle limit and output checking
  // ---------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_n++;
    if (cyc_n > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("decimal_int_list_validator: mismatch");
      $finish;
    end
  end

  // Check each verdict item taken at this edge, then pick the next stall
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict item with none expected: verdict %0d reason %0d total %0d",
                   $time, verdict_o, reject_reason_o, token_total_o);
          fail_n++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict_o !== want.verdict) begin
            $display("%0t: verdict expected %0d, actual %0d",
                     $time, want.verdict, verdict_o);
            fail_n++;
          end
          if (reject_reason_o !== want.reason) begin
            $display("%0t: reject_reason expected %0d, actual %0d",
                     $time, want.reason, reject_reason_o);
            fail_n++;
          end
          if (token_total_o !== want.total) begin
            $display("%0t: token_total expected %0d, actual %0d",
                     $time, want.total, token_total_o);
            fail_n++;
          end
        end
      end
      out_stall_i <= gaps_on && ($urandom_range(99) < 31);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one item, hold it until taken, then feed it to the predictor
  task automatic send_step(input logic [7:0] c, input logic hc,
                           input logic te, input logic le);
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ch_i        <= c;
    has_char_i  <= hc;
    token_end_i <= te;
    list_end_i  <= le;
    do @(posedge clk_i); while (in_stall_o);
    predict_step(c, hc, te, le);
    if (hc || te || le) begin
      item_n++;
    end
  endtask

  // Close the list with an item that carries no character
  task automatic end_list();
    send_step(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
  endtask

  // Send a token's characters; the closing flags ride on the last one
  task automatic send_chars(input char_q_t chars, input logic te, input logic le);
    int n;
    n = chars.size();
    if (n == 0) begin
      if (te || le) begin
        send_step(8'($urandom_range(0, 255)), 1'b0, te, le);
      end
      return;
    end
    for (int i = 0; i < n; i++) begin
      send_step(chars[i], 1'b1, te && i == n - 1, le && i == n - 1);
    end
  endtask

  function automatic char_q_t text_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  task automatic send_text(input string s, input logic te, input logic le);
    send_chars(text_chars(s), te, le);
  endtask

  // Each token closed by its own last character; the last one ends the list
  task automatic send_list(input string toks[$]);
    for (int i = 0; i < toks.size(); i++) begin
      send_text(toks[i], 1'b1, i == toks.size() - 1);
    end
  endtask

  // Decimal text of a value: small, near a bound, or anywhere in 32 bits,
  // with an occasional plus sign or leading zero
  function automatic string number_text();
    longint val;
    string  s;
    int     r;
    r = $urandom_range(99);
    if (r < 30) begin
      val = $urandom_range(0, 20);
      if ($urandom_range(1)) begin
        val = -val;
      end
    end else if (r < 55) begin
      val = longint'(2147483644) + longint'($urandom_range(0, 6));
      if ($urandom_range(1)) begin
        val = -val - 1;
      end
    end else begin
      val = $signed($urandom);
    end
    s = $sformatf("%0d", val);
    if (val >= 0 && $urandom_range(3) == 0) begin
      s = {"+", s};
    end
    if ($urandom_range(7) == 0) begin
      if (s[0] == "-" || s[0] == "+") begin
        s = {s.substr(0, 0), "0", s.substr(1, s.len() - 1)};
      end else begin
        s = {"0", s};
      end
    end
    return s;
  endfunction

  // One list of mostly well-formed numbers, with repeats, bad characters,
  // lone signs, empty tokens and the odd ignored item mixed in
  task automatic send_random_list();
    int       n;
    int       r;
    int       base;
    string    tok;
    string    used[$];
    char_q_t  chars;
    logic [7:0] c;
    if ($urandom_range(99) < 2) begin
      // Long list of distinct short values to fill the table
      base = $urandom_range(0, 1000);
      n = $urandom_range(62, 68);
      for (int k = 0; k < n; k++) begin
        send_text($sformatf("%0d", base + k), 1'b1, k == n - 1);
      end
      return;
    end
    n = $urandom_range(0, 7);
    if (n == 0) begin
      end_list();
      return;
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 6) begin
        send_step(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      end
      r = $urandom_range(99);
      if (r < 12 && used.size() > 0) begin
        chars = text_chars(used[$urandom_range(0, used.size() - 1)]);
      end else if (r < 20) begin
        chars = text_chars(number_text());
        if ($urandom_range(1)) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = $urandom_range(1) ? dilv_pkg::CharMinus : dilv_pkg::CharPlus;
        end
        chars.insert($urandom_range(0, chars.size()), c);
      end else if (r < 24) begin
        chars = text_chars($urandom_range(1) ? "-" : "+");
      end else if (r < 29) begin
        chars.delete();
      end else begin
        tok = number_text();
        used.push_back(tok);
        chars = text_chars(tok);
      end
      if (k != n - 1) begin
        send_chars(chars, 1'b1, 1'b0);
      end else begin
        // Vary how the list is closed
        case ($urandom_range(0, 2))
          0: begin
            send_chars(chars, 1'b1, 1'b1);
          end
          1: begin
            send_chars(chars, 1'b0, 1'b1);
          end
          default: begin
            send_chars(chars, 1'b1, 1'b0);
            end_list();
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Both bounds, including the plus-signed eleven-character maximum
  task automatic test_bounds();
    send_list('{"-2147483648", "+2147483647", "0", "+0000000001"});
    send_list('{"2147483648"});
    send_list('{"-2147483649"});
    send_list('{"02147483647"});
    send_list('{"+02147483647"});
  endtask

  // Bad characters, a sign past the first place and lone signs
  task automatic test_format();
    send_list('{"1a"});
    send_list('{"1-2"});
    send_list('{"4", "+"});
    send_text("-", 1'b0, 1'b1);
  endtask

  // Repeats, empty tokens as zero, an empty list and a token left open
  task automatic test_dup_empty();
    send_list('{"7", "-3", "7"});
    send_list('{"", "-0"});
    end_list();
    send_text("12", 1'b0, 1'b1);
  endtask

  // Format and range faults displace an earlier repeat; range does not displace format
  task automatic test_precedence();
    send_list('{"5", "5", "x"});
    send_list('{"5", "5", "99999999999"});
    send_list('{"z", "2147483648"});
  endtask

  // Overflow the table, fill it and repeat, and overflow it before a format fault
  task automatic test_table_full();
    for (int k = 0; k <= MAX_TOK + 1; k++) begin
      send_text($sformatf("%0d", k), 1'b1, k == MAX_TOK + 1);
    end
    for (int k = 0; k < MAX_TOK; k++) begin
      send_text($sformatf("%0d", k), 1'b1, 1'b0);
    end
    send_list('{"3", "100"});
    for (int k = 0; k <= MAX_TOK; k++) begin
      send_text($sformatf("%0d", -k - 1), 1'b1, 1'b0);
    end
    send_list('{"-"});
  endtask

  task automatic test_random();
    int start;
    start = item_n;
    // Full rate on both channels first, then random idling
    gaps_on = 1'b0;
    while (item_n < start + RANDOM_ITEMS / 3) begin
      send_random_list();
    end
    gaps_on = 1'b1;
    while (item_n < start + RANDOM_ITEMS) begin
      send_random_list();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bounds();
    test_format();
    test_dup_empty();
    test_precedence();
    test_table_full();
    test_random();
    in_valid_i <= 1'b0;
    // Drain outstanding verdicts, then allow for a late stray item
    while (verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MAX_TOK + 8) @(posedge clk_i);
    if (fail_n == 0) begin
      $display("decimal_int_list_validator: match");
    end else begin
      $display("decimal_int_list_validator: mismatch");
    end
    $finish;
  end

endmodule
